// ===== src/command_centroid_selector_dwell_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the command centroid selector
// Shared property forms used by the checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef COMMAND_CENTROID_SELECTOR_DWELL_ASSERT_SVH
`define COMMAND_CENTROID_SELECTOR_DWELL_ASSERT_SVH

// Same-cycle implication, held off during reset
`define CCSD_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ccsd: same-cycle check failed");

// Next-cycle implication, held off during reset
`define CCSD_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ccsd: next-cycle check failed");

`endif

// ===== src/ccsd_pkg.sv =====
// ----------------------------------------------------------------------------
// ccsd_pkg
// Types, constants and the centroid set of the command centroid selector.
// ----------------------------------------------------------------------------
package ccsd_pkg;

  // Field widths
  localparam int unsigned ENV_W     = 6;
  localparam int unsigned CMD_W     = 16;
  localparam int unsigned IDX_W     = 4;
  localparam int unsigned DWELL_W   = 8;
  localparam int unsigned YAW_W     = 16;
  localparam int unsigned CFG_W     = 16;
  localparam int unsigned CFG_IDX_W = 1;
  // (ex^2 + ey^2) << 16 plus weight * ew^2 stays below 2^50
  localparam int unsigned COST_W    = 50;

  localparam int unsigned MAX_CENTROIDS = 16;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_YAW_GAIN    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DWELL_LIMIT = 1'd1;

  // Register reset values
  localparam logic [YAW_W-1:0]   YAW_GAIN_RST    = 16'd13107;
  localparam logic [DWELL_W-1:0] DWELL_LIMIT_RST = 8'd3;

  // Centroid triples (vx, vy, wz), Q4.12; entries past the twelfth are zero
  localparam logic signed [CMD_W-1:0] CENTROIDS [0:MAX_CENTROIDS*3-1] = '{
    16'sd4,     -16'sd8,    -16'sd41,
    16'sd1851,  16'sd905,   16'sd1446,
    16'sd5243,  -16'sd524,  16'sd356,
    16'sd1753,  -16'sd106,  -16'sd1909,
    -16'sd889,  16'sd6623,  16'sd238,
    -16'sd6038, 16'sd315,   16'sd344,
    -16'sd1556, -16'sd4407, 16'sd20,
    -16'sd1229, -16'sd6889, -16'sd913,
    16'sd315,   16'sd561,   16'sd16757,
    16'sd393,   -16'sd618,  -16'sd15843,
    16'sd217,   16'sd643,   -16'sd1307,
    16'sd3031,  -16'sd500,  16'sd823,
    16'sd0,     16'sd0,     16'sd0,
    16'sd0,     16'sd0,     16'sd0,
    16'sd0,     16'sd0,     16'sd0,
    16'sd0,     16'sd0,     16'sd0
  };

  // Input beat
  typedef struct packed {
    logic        [ENV_W-1:0] env_index;
    logic signed [CMD_W-1:0] cmd_vx;
    logic signed [CMD_W-1:0] cmd_vy;
    logic signed [CMD_W-1:0] cmd_wz;
  } cmd_t;

  // Result beat
  typedef struct packed {
    logic [IDX_W-1:0]   active_index;
    logic [IDX_W-1:0]   wanted_index;
    logic               switched;
    logic [DWELL_W-1:0] dwell_now;
  } res_t;

  // Per-environment selector record
  typedef struct packed {
    logic [IDX_W-1:0]   active;
    logic [IDX_W-1:0]   pending;
    logic [DWELL_W-1:0] dwell;
  } env_rec_t;

  // Running best handed from cell to cell
  typedef struct packed {
    logic              vld;
    logic [COST_W-1:0] cost;
    logic [IDX_W-1:0]  idx;
  } best_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RUN,
    ST_UPD
  } state_t;

endpackage

// ===== src/ccsd_cell.sv =====
// ----------------------------------------------------------------------------
// ccsd_cell
// One centroid: a three-stage cost pipeline and a compare stage that takes
// the running best from the left neighbor and hands it on to the right.
// ----------------------------------------------------------------------------
module ccsd_cell #(
  parameter int unsigned IDX = 0
) (
  input  logic                         clk,
  input  logic                         rst,
  input  ccsd_pkg::cmd_t               cmd,
  input  logic [ccsd_pkg::YAW_W-1:0]   yaw_gain,
  input  ccsd_pkg::best_t              best_in,
  output ccsd_pkg::best_t              best_out
);

  localparam logic signed [ccsd_pkg::CMD_W-1:0] CX = ccsd_pkg::CENTROIDS[IDX*3];
  localparam logic signed [ccsd_pkg::CMD_W-1:0] CY = ccsd_pkg::CENTROIDS[IDX*3+1];
  localparam logic signed [ccsd_pkg::CMD_W-1:0] CW = ccsd_pkg::CENTROIDS[IDX*3+2];
  localparam logic [ccsd_pkg::IDX_W-1:0] MY_IDX = ccsd_pkg::IDX_W'(IDX);

  logic signed [ccsd_pkg::CMD_W:0] ex, ey, ew;
  logic [ccsd_pkg::CMD_W-1:0]      mx, my, mw;
  logic [31:0]                     sx, sy, sw;
  logic [32:0]                     sxy;
  logic [47:0]                     wp;
  logic [ccsd_pkg::COST_W-1:0]     cost;
  logic                            vld;
  logic [ccsd_pkg::COST_W-1:0]     run_cost;
  logic [ccsd_pkg::IDX_W-1:0]      best_idx;

  // Errors as 17-bit differences, magnitudes fit 16 bits
  always_comb begin
    ex = {CX[ccsd_pkg::CMD_W-1], CX} - {cmd.cmd_vx[ccsd_pkg::CMD_W-1], cmd.cmd_vx};
    ey = {CY[ccsd_pkg::CMD_W-1], CY} - {cmd.cmd_vy[ccsd_pkg::CMD_W-1], cmd.cmd_vy};
    ew = {CW[ccsd_pkg::CMD_W-1], CW} - {cmd.cmd_wz[ccsd_pkg::CMD_W-1], cmd.cmd_wz};
    mx = ex[ccsd_pkg::CMD_W] ? ccsd_pkg::CMD_W'(-ex) : ex[ccsd_pkg::CMD_W-1:0];
    my = ey[ccsd_pkg::CMD_W] ? ccsd_pkg::CMD_W'(-ey) : ey[ccsd_pkg::CMD_W-1:0];
    mw = ew[ccsd_pkg::CMD_W] ? ccsd_pkg::CMD_W'(-ew) : ew[ccsd_pkg::CMD_W-1:0];
  end

  // Cost pipeline: squares, then weight product and x/y sum, then final sum
  always_ff @(posedge clk) begin
    sx   <= 32'(mx) * 32'(mx);
    sy   <= 32'(my) * 32'(my);
    sw   <= 32'(mw) * 32'(mw);
    sxy  <= 33'(sx) + 33'(sy);
    wp   <= 48'(yaw_gain) * 48'(sw);
    cost <= ccsd_pkg::COST_W'({sxy, 16'd0}) + ccsd_pkg::COST_W'(wp);
  end

  // Compare stage: strictly smaller cost takes over, so lower index wins ties
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else begin
      vld <= best_in.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (best_in.vld) begin
      if (cost < best_in.cost) begin
        run_cost <= cost;
        best_idx <= MY_IDX;
      end else begin
        run_cost <= best_in.cost;
        best_idx <= best_in.idx;
      end
    end
  end

  assign best_out.vld  = vld;
  assign best_out.cost = run_cost;
  assign best_out.idx  = best_idx;

endmodule

// ===== src/ccsd_env_mem.sv =====
// ----------------------------------------------------------------------------
// ccsd_env_mem
// Per-environment selector records: one write port, one registered read.
// ----------------------------------------------------------------------------
module ccsd_env_mem #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [AW-1:0]        waddr,
  input  ccsd_pkg::env_rec_t   wdata,
  input  logic [AW-1:0]        raddr,
  output ccsd_pkg::env_rec_t   rdata
);

  ccsd_pkg::env_rec_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== src/command_centroid_selector_dwell.sv =====
// ----------------------------------------------------------------------------
// command_centroid_selector_dwell
// Nearest-centroid selection of a velocity command with per-environment
// dwell debouncing of the active centroid.
// ----------------------------------------------------------------------------
// One command beat is taken at a time and yields one result beat. From
// acceptance to the result register, the cost pipeline inside every cell
// runs first, then the running best walks the row of centroid cells one
// cell per cycle, then the winner is captured and, once the result
// register is free, the environment record is updated. The result register
// frees the input side, so the next command is taken while a result waits.
// After reset the environment store is cleared one entry per cycle, every
// one of the ENVS entries, before the first command is taken; configuration
// writes are taken at any time.
module command_centroid_selector_dwell #(
  parameter int unsigned NUM_CENTROIDS = 12,
  parameter int unsigned ENVS          = 64
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cmd_valid,
  output logic                              cmd_stall,
  input  ccsd_pkg::cmd_t                    cmd_data,
  output logic                              res_valid,
  input  logic                              res_stall,
  output ccsd_pkg::res_t                    res_data,
  input  logic                              cfg_wr_en,
  input  logic [ccsd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ccsd_pkg::CFG_W-1:0]        cfg_wdata
);

  `include "command_centroid_selector_dwell_assert.svh"

  localparam int unsigned ENV_AW   = (ENVS > 1) ? $clog2(ENVS) : 1;
  localparam int unsigned COST_LAT = 3;
  localparam int unsigned CNT_W    = $clog2(COST_LAT + 2);
  localparam logic [CNT_W-1:0] CNT_START = CNT_W'(COST_LAT);
  localparam logic [CNT_W-1:0] CNT_DONE  = CNT_W'(COST_LAT + 1);
  localparam logic [ENV_AW-1:0] CLR_LAST = ENV_AW'(ENVS - 1);
  localparam logic [10:0] ENVS_L = 11'(ENVS);

  ccsd_pkg::state_t               state, state_next;
  logic [ENV_AW-1:0]              clr;
  logic [CNT_W-1:0]               run_cnt;
  logic [ccsd_pkg::YAW_W-1:0]     yaw_gain;
  logic [ccsd_pkg::DWELL_W-1:0]   dwell_limit;
  ccsd_pkg::cmd_t                 cmd_q;
  logic [ENV_AW-1:0]              env_addr;
  logic                           in_range;
  logic [ccsd_pkg::IDX_W-1:0]     want;
  ccsd_pkg::env_rec_t             rd_rec;
  ccsd_pkg::env_rec_t             upd_rec;
  ccsd_pkg::res_t                 upd_res;
  ccsd_pkg::res_t                 res_q;
  logic                           res_vld;
  logic                           accept;
  logic                           out_free;
  logic                           commit;
  logic                           mem_we;
  logic [ENV_AW-1:0]              mem_waddr;
  ccsd_pkg::env_rec_t             mem_wdata;
  logic [ccsd_pkg::DWELL_W:0]     dwell_inc;
  ccsd_pkg::best_t                link [NUM_CENTROIDS+1];

  assign accept   = cmd_valid && !cmd_stall;
  assign out_free = !res_vld || !res_stall;
  assign commit   = (state == ccsd_pkg::ST_UPD) && out_free;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      yaw_gain    <= ccsd_pkg::YAW_GAIN_RST;
      dwell_limit <= ccsd_pkg::DWELL_LIMIT_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        ccsd_pkg::CFG_YAW_GAIN:    yaw_gain    <= cfg_wdata;
        ccsd_pkg::CFG_DWELL_LIMIT: dwell_limit <= cfg_wdata[ccsd_pkg::DWELL_W-1:0];
        default: ;
      endcase
    end
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ccsd_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state and handshake
  always_comb begin
    state_next = state;
    cmd_stall  = 1'b1;
    case (state)
      ccsd_pkg::ST_CLEAR: begin
        if (clr == CLR_LAST) state_next = ccsd_pkg::ST_IDLE;
      end
      ccsd_pkg::ST_IDLE: begin
        cmd_stall = 1'b0;
        if (cmd_valid) state_next = ccsd_pkg::ST_RUN;
      end
      ccsd_pkg::ST_RUN: begin
        if (link[NUM_CENTROIDS].vld) state_next = ccsd_pkg::ST_UPD;
      end
      ccsd_pkg::ST_UPD: begin
        if (out_free) state_next = ccsd_pkg::ST_IDLE;
      end
      default: state_next = ccsd_pkg::ST_CLEAR;
    endcase
  end

  // Clearing sweep counter and cost latency counter
  always_ff @(posedge clk) begin
    if (rst) begin
      clr     <= '0;
      run_cnt <= '0;
    end else begin
      if (state == ccsd_pkg::ST_CLEAR) clr <= clr + 1'b1;
      if (accept) begin
        run_cnt <= '0;
      end else if (state == ccsd_pkg::ST_RUN && run_cnt != CNT_DONE) begin
        run_cnt <= run_cnt + 1'b1;
      end
    end
  end

  // Command capture, held for the whole beat
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q    <= cmd_data;
      env_addr <= ENV_AW'(cmd_data.env_index);
      in_range <= {5'd0, cmd_data.env_index} < ENVS_L;
    end
    if (state == ccsd_pkg::ST_RUN && link[NUM_CENTROIDS].vld) begin
      want <= link[NUM_CENTROIDS].idx;
    end
  end

  // Head of the chain: worst possible cost so the first cell always takes over
  assign link[0].vld  = (state == ccsd_pkg::ST_RUN) && (run_cnt == CNT_START);
  assign link[0].cost = '1;
  assign link[0].idx  = '0;

  // Row of centroid cells
  for (genvar k = 0; k < NUM_CENTROIDS; k++) begin : g_cell
    ccsd_cell #(
      .IDX(k)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .cmd     (cmd_q),
      .yaw_gain(yaw_gain),
      .best_in (link[k]),
      .best_out(link[k+1])
    );
  end

  // Dwell update of the environment record
  always_comb begin
    upd_rec   = rd_rec;
    upd_res   = '0;
    dwell_inc = {1'b0, rd_rec.dwell} + 1'b1;
    upd_res.wanted_index = want;
    if (in_range) begin
      if (want == rd_rec.active || want != rd_rec.pending) begin
        upd_rec.pending = want;
        upd_rec.dwell   = '0;
      end else if (dwell_inc >= {1'b0, dwell_limit}) begin
        upd_rec.active   = want;
        upd_rec.dwell    = '0;
        upd_res.switched = 1'b1;
      end else begin
        upd_rec.dwell = dwell_inc[ccsd_pkg::DWELL_W-1:0];
      end
      upd_res.active_index = upd_rec.active;
      upd_res.dwell_now    = upd_rec.dwell;
    end
  end

  // Store write: clearing sweep or record update
  always_comb begin
    if (state == ccsd_pkg::ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr;
      mem_wdata = '0;
    end else begin
      mem_we    = commit && in_range;
      mem_waddr = env_addr;
      mem_wdata = upd_rec;
    end
  end

  ccsd_env_mem #(
    .DEPTH(ENVS),
    .AW   (ENV_AW)
  ) u_env_mem (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(env_addr),
    .rdata(rd_rec)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_vld <= 1'b0;
    end else if (commit) begin
      res_vld <= 1'b1;
    end else if (res_vld && !res_stall) begin
      res_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) res_q <= upd_res;
  end

  assign res_valid = res_vld;
  assign res_data  = res_q;

  // Checks
  `CCSD_ASSERT_IMPLY(a_chain_in_run, clk, rst, link[NUM_CENTROIDS].vld, state == ccsd_pkg::ST_RUN)
  `CCSD_ASSERT_NEXT(a_accept_runs, clk, rst, accept, state == ccsd_pkg::ST_RUN)
  `CCSD_ASSERT_IMPLY(a_want_range, clk, rst, res_valid, {1'b0, res_data.wanted_index} < 5'(NUM_CENTROIDS))
  `CCSD_ASSERT_IMPLY(a_switch_clean, clk, rst, res_valid && res_data.switched, (res_data.active_index == res_data.wanted_index) && (res_data.dwell_now == 8'd0))

endmodule
